@@ src/calibrated_pitch_to_cv_interpolator_core_defines.svh @@
// Assertion macros shared by the pitch-to-CV interpolator RTL.
`ifndef CALIBRATED_PITCH_TO_CV_INTERPOLATOR_CORE_DEFINES_SVH
`define CALIBRATED_PITCH_TO_CV_INTERPOLATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CPCI_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CPCI_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/cpci_pkg.sv @@
// Types, constants and the CV ROM of the pitch-to-CV interpolator.
package cpci_pkg;

    // Table geometry
    localparam int TABLE_POINTS = 40;
    localparam int IDX_W        = (TABLE_POINTS > 1) ? $clog2(TABLE_POINTS) : 1;
    localparam int CNT_W        = $clog2(TABLE_POINTS + 1);

    // Field and datapath widths
    localparam int HZ_W   = 24;
    localparam int CV_W   = 16;
    localparam int DX_W   = HZ_W + 1;        // signed frequency difference
    localparam int DY_W   = CV_W + 1;        // signed CV difference
    localparam int PROD_W = DX_W + DY_W;     // signed product dy * dx
    localparam int DEN_W  = HZ_W;            // magnitude of frequency difference
    localparam int QS_W   = CV_W + 1;        // quotient bits that can still fit
    localparam int SUM_W  = QS_W + 2;        // y1 +/- small quotient

    // CV ROM: -1.6 V to 5.0 V in signed Q3.12
    localparam int ROM_SIZE = 40;
    localparam logic signed [CV_W-1:0] CV_ROM [ROM_SIZE] = '{
        -16'sd6554, -16'sd5734, -16'sd5325, -16'sd4506, -16'sd3686,
        -16'sd3277, -16'sd2458, -16'sd1638, -16'sd819,  -16'sd410,
        16'sd410,   16'sd1229,  16'sd1638,  16'sd2458,  16'sd3277,
        16'sd3686,  16'sd4506,  16'sd5325,  16'sd5734,  16'sd6554,
        16'sd7373,  16'sd8192,  16'sd8602,  16'sd9421,  16'sd10240,
        16'sd10650, 16'sd11469, 16'sd12288, 16'sd12698, 16'sd13517,
        16'sd14336, 16'sd14746, 16'sd15565, 16'sd16384, 16'sd17203,
        16'sd17613, 16'sd18432, 16'sd19251, 16'sd19661, 16'sd20480
    };
    localparam logic signed [CV_W-1:0] CV_LOW = -16'sd6554;
    localparam logic signed [CV_W-1:0] CV_MAX = 16'sd32767;
    localparam logic signed [CV_W-1:0] CV_MIN = -16'sd32768;

    // Request codes
    typedef enum logic [1:0] {
        REQ_CAL   = 2'd0,
        REQ_QUERY = 2'd1,
        REQ_CLEAR = 2'd2
    } req_code_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_FIN
    } ctrl_state_t;

    // Channel payloads
    typedef struct packed {
        logic [1:0]      req_type;
        logic [HZ_W-1:0] value_hz;
        logic            record_on;
    } in_item_t;

    typedef struct packed {
        logic signed [CV_W-1:0] cv_out;
        logic                   table_complete_flag;
    } out_item_t;

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [DEN_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quotient;
    } div_rsp_t;

    // ROM lookup, clamped to the last entry
    function automatic logic signed [CV_W-1:0] rom_cv(input logic [IDX_W-1:0] idx);
        logic signed [CV_W-1:0] cv;
        if (int'(idx) >= ROM_SIZE) begin
            cv = CV_ROM[ROM_SIZE-1];
        end else begin
            cv = CV_ROM[idx];
        end
        return cv;
    endfunction

endpackage

@@ src/cpci_freq_ram.sv @@
// Frequency table memory: one write port, one registered read port.
module cpci_freq_ram (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [cpci_pkg::IDX_W-1:0]   wr_addr,
    input  logic [cpci_pkg::HZ_W-1:0]    wr_data,
    input  logic [cpci_pkg::IDX_W-1:0]   rd_addr,
    output logic [cpci_pkg::HZ_W-1:0]    rd_data
);

    logic [cpci_pkg::HZ_W-1:0] mem [cpci_pkg::TABLE_POINTS];
    logic [cpci_pkg::HZ_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/cpci_divider.sv @@
// Restoring divider, one quotient bit per cycle.
module cpci_divider (
    input  logic                aclk,
    input  logic                aresetn,
    input  cpci_pkg::div_req_t  req,
    output cpci_pkg::div_rsp_t  rsp
);

    localparam int CNT_W = $clog2(cpci_pkg::PROD_W + 1);

    logic [cpci_pkg::DEN_W-1:0]  rem_reg, rem_next;
    logic [cpci_pkg::PROD_W-1:0] quo_reg, quo_next;
    logic [cpci_pkg::DEN_W-1:0]  dvs_reg, dvs_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [cpci_pkg::DEN_W:0]    shifted;
    logic                        fits;

    // One shift-subtract step
    always_comb begin
        shifted = {rem_reg, quo_reg[cpci_pkg::PROD_W-1]};
        fits    = shifted >= {1'b0, dvs_reg};
    end

    // Next-state logic; the remainder always stays below the divisor
    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = CNT_W'(cpci_pkg::PROD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? cpci_pkg::DEN_W'(shifted - {1'b0, dvs_reg})
                            : shifted[cpci_pkg::DEN_W-1:0];
            quo_next = {quo_reg[cpci_pkg::PROD_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ src/calibrated_pitch_to_cv_interpolator_core.sv @@
// Top level of the calibrated pitch-to-CV interpolator.
//
//  Channel | Ports                     | Carries
//  --------+---------------------------+------------------------------------------
//  input   | s_valid s_ready s_data    | request code, frequency Q16.8, record switch
//  result  | m_valid m_ready m_data    | CV Q3.12, table complete flag
//
// Calibration, clear, ignored and early queries: result registered at the accept edge.
// Query on a complete table, hit at entry k: the one-entry-per-cycle scan, then ST_MUL,
// ST_PREP, the restoring divider (42 steps) and ST_FIN, which registers the result once
// the output is free; entry 0 and flat segments go from the scan straight to ST_FIN.
// Reset (synchronous, aresetn low) clears count, complete flag and held CV, not the table.
// One transaction at a time; s_ready is low during a query and while a result waits.
`include "calibrated_pitch_to_cv_interpolator_core_defines.svh"

module calibrated_pitch_to_cv_interpolator_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  cpci_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output cpci_pkg::out_item_t  m_data
);

    localparam int IDX_W = cpci_pkg::IDX_W;
    localparam int CNT_W = cpci_pkg::CNT_W;
    localparam int HZ_W  = cpci_pkg::HZ_W;
    localparam int CV_W  = cpci_pkg::CV_W;

    // Control state
    cpci_pkg::ctrl_state_t  state_reg, state_next;
    logic [CNT_W-1:0]       points_recorded_reg, points_recorded_next;
    logic                   table_done_reg, table_done_next;
    logic signed [CV_W-1:0] held_cv_reg, held_cv_next;
    logic                   m_valid_reg, m_valid_next;
    cpci_pkg::out_item_t    m_data_reg, m_data_next;

    // Query datapath
    logic [HZ_W-1:0]                    target_reg, target_next;
    logic [IDX_W-1:0]                   scan_idx_reg, scan_idx_next;
    logic [HZ_W-1:0]                    prev_reg, prev_next;
    logic signed [CV_W-1:0]             y1_reg, y1_next;
    logic signed [cpci_pkg::DX_W-1:0]   dx_reg, dx_next;
    logic signed [cpci_pkg::DX_W-1:0]   den_reg, den_next;
    logic signed [cpci_pkg::DY_W-1:0]   dy_reg, dy_next;
    logic                               quick_reg, quick_next;
    logic signed [CV_W-1:0]             quick_cv_reg, quick_cv_next;
    logic signed [cpci_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic                               neg_reg, neg_next;

    // Handshake and control
    logic             s_fire;
    logic             out_free;
    logic             scan_en;
    logic             fin_load;
    logic             div_start;
    logic [IDX_W-1:0] rd_addr;
    logic [HZ_W-1:0]  rd_data;

    // Accept-cycle decode
    logic                   clr;
    logic                   done_eff;
    logic [CNT_W-1:0]       pts_eff;
    logic signed [CV_W-1:0] held_eff;
    logic                   cal;
    logic                   full;
    logic                   go_query;
    logic [CNT_W-1:0]       cnt_inc;
    logic [IDX_W-1:0]       rom_next_idx;
    logic                   wr_en;

    // Scan compare
    logic                   scan_hit;
    logic signed [CV_W-1:0] y1_rom;
    logic signed [CV_W-1:0] y2_rom;

    // Divider setup and final result
    logic                         prod_neg;
    logic                         den_neg;
    logic [cpci_pkg::PROD_W-1:0]  mag;
    logic [cpci_pkg::DX_W-1:0]    den_abs;
    cpci_pkg::div_req_t           div_req;
    cpci_pkg::div_rsp_t           div_rsp;
    logic                         q_big;
    logic [cpci_pkg::SUM_W-1:0]   q_small;
    logic signed [cpci_pkg::SUM_W-1:0] sum;
    logic signed [CV_W-1:0]       interp_cv;
    logic signed [CV_W-1:0]       result_cv;

    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Frequency table
    cpci_freq_ram u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (pts_eff[IDX_W-1:0]),
        .wr_data (s_data.value_hz),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Divider
    cpci_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Decode of the accepted transaction: clear first, then record switch, then request
    always_comb begin
        clr      = s_data.req_type == cpci_pkg::REQ_CLEAR;
        done_eff = clr ? 1'b0 : table_done_reg;
        pts_eff  = clr ? '0 : points_recorded_reg;
        held_eff = (clr || (!s_data.record_on && !done_eff)) ? cpci_pkg::CV_LOW : held_cv_reg;
        cal      = (s_data.req_type == cpci_pkg::REQ_CAL) && s_data.record_on && !done_eff;
        full     = pts_eff == CNT_W'(cpci_pkg::TABLE_POINTS);
        go_query = (s_data.req_type == cpci_pkg::REQ_QUERY) && done_eff;
        cnt_inc  = pts_eff + CNT_W'(1);
        if (cnt_inc >= CNT_W'(cpci_pkg::TABLE_POINTS)) begin
            rom_next_idx = IDX_W'(cpci_pkg::TABLE_POINTS - 1);
        end else begin
            rom_next_idx = cnt_inc[IDX_W-1:0];
        end
        wr_en = s_fire && cal && !full;
    end

    // Scan compare: first entry at or above the target, else the last one
    always_comb begin
        scan_hit = (rd_data >= target_reg)
                   || (scan_idx_reg == IDX_W'(cpci_pkg::TABLE_POINTS - 1));
        y2_rom   = cpci_pkg::rom_cv(scan_idx_reg);
        y1_rom   = cpci_pkg::rom_cv(scan_idx_reg - IDX_W'(1));
    end

    // Divider operands: magnitudes with rounding offset
    always_comb begin
        prod_neg = prod_reg[cpci_pkg::PROD_W-1];
        den_neg  = den_reg[cpci_pkg::DX_W-1];
        mag      = prod_neg ? cpci_pkg::PROD_W'(-prod_reg) : cpci_pkg::PROD_W'(prod_reg);
        den_abs  = den_neg ? cpci_pkg::DX_W'(-den_reg) : cpci_pkg::DX_W'(den_reg);
        div_req.start    = div_start;
        div_req.divisor  = den_abs[cpci_pkg::DEN_W-1:0];
        div_req.dividend = mag + cpci_pkg::PROD_W'(den_abs[cpci_pkg::DEN_W-1:1]);
    end

    // Final sum with saturation
    always_comb begin
        q_big   = |div_rsp.quotient[cpci_pkg::PROD_W-1:cpci_pkg::QS_W];
        q_small = cpci_pkg::SUM_W'(div_rsp.quotient[cpci_pkg::QS_W-1:0]);
        if (neg_reg) begin
            sum = cpci_pkg::SUM_W'(y1_reg) - $signed(q_small);
        end else begin
            sum = cpci_pkg::SUM_W'(y1_reg) + $signed(q_small);
        end
        if (q_big) begin
            interp_cv = neg_reg ? cpci_pkg::CV_MIN : cpci_pkg::CV_MAX;
        end else if (sum > cpci_pkg::SUM_W'(cpci_pkg::CV_MAX)) begin
            interp_cv = cpci_pkg::CV_MAX;
        end else if (sum < cpci_pkg::SUM_W'(cpci_pkg::CV_MIN)) begin
            interp_cv = cpci_pkg::CV_MIN;
        end else begin
            interp_cv = sum[CV_W-1:0];
        end
        result_cv = quick_reg ? quick_cv_reg : interp_cv;
    end

    // Controller: next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cpci_pkg::ST_IDLE: begin
                if (s_fire && go_query) begin
                    state_next = cpci_pkg::ST_SCAN;
                end
            end
            cpci_pkg::ST_SCAN: begin
                if (scan_hit) begin
                    if ((scan_idx_reg == '0) || (rd_data == prev_reg)) begin
                        state_next = cpci_pkg::ST_FIN;
                    end else begin
                        state_next = cpci_pkg::ST_MUL;
                    end
                end
            end
            cpci_pkg::ST_MUL:  state_next = cpci_pkg::ST_PREP;
            cpci_pkg::ST_PREP: state_next = cpci_pkg::ST_DIV;
            cpci_pkg::ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = cpci_pkg::ST_FIN;
                end
            end
            cpci_pkg::ST_FIN: begin
                if (out_free) begin
                    state_next = cpci_pkg::ST_IDLE;
                end
            end
            default: state_next = cpci_pkg::ST_IDLE;
        endcase
    end

    // Controller: outputs
    always_comb begin
        s_ready   = 1'b0;
        scan_en   = 1'b0;
        div_start = 1'b0;
        fin_load  = 1'b0;
        rd_addr   = '0;
        case (state_reg)
            cpci_pkg::ST_IDLE: s_ready = out_free;
            cpci_pkg::ST_SCAN: begin
                scan_en = 1'b1;
                if (scan_idx_reg == IDX_W'(cpci_pkg::TABLE_POINTS - 1)) begin
                    rd_addr = scan_idx_reg;
                end else begin
                    rd_addr = scan_idx_reg + IDX_W'(1);
                end
            end
            cpci_pkg::ST_MUL:  ;
            cpci_pkg::ST_PREP: div_start = 1'b1;
            cpci_pkg::ST_DIV:  ;
            cpci_pkg::ST_FIN:  fin_load = out_free;
            default: ;
        endcase
    end

    // Table state, held CV and result register
    always_comb begin
        points_recorded_next = points_recorded_reg;
        table_done_next      = table_done_reg;
        held_cv_next         = held_cv_reg;
        m_valid_next         = m_valid_reg && !m_ready;
        m_data_next          = m_data_reg;
        if (s_fire) begin
            table_done_next      = (cal && full) ? 1'b1 : done_eff;
            points_recorded_next = cal ? (full ? '0 : cnt_inc) : pts_eff;
            held_cv_next         = (cal && !full) ? cpci_pkg::rom_cv(rom_next_idx) : held_eff;
            if (!go_query) begin
                m_valid_next                    = 1'b1;
                m_data_next.cv_out              = held_cv_next;
                m_data_next.table_complete_flag = table_done_next;
            end
        end else if (fin_load) begin
            held_cv_next                    = result_cv;
            m_valid_next                    = 1'b1;
            m_data_next.cv_out              = result_cv;
            m_data_next.table_complete_flag = table_done_reg;
        end
    end

    // Query datapath registers
    always_comb begin
        target_next   = target_reg;
        scan_idx_next = scan_idx_reg;
        prev_next     = prev_reg;
        y1_next       = y1_reg;
        dx_next       = dx_reg;
        den_next      = den_reg;
        dy_next       = dy_reg;
        quick_next    = quick_reg;
        quick_cv_next = quick_cv_reg;
        prod_next     = prod_reg;
        neg_next      = neg_reg;
        if (s_fire) begin
            target_next   = s_data.value_hz;
            scan_idx_next = '0;
        end
        if (scan_en) begin
            if (scan_hit) begin
                y1_next       = y1_rom;
                dy_next       = cpci_pkg::DY_W'(y2_rom) - cpci_pkg::DY_W'(y1_rom);
                dx_next       = $signed({1'b0, target_reg}) - $signed({1'b0, prev_reg});
                den_next      = $signed({1'b0, rd_data}) - $signed({1'b0, prev_reg});
                quick_next    = (scan_idx_reg == '0) || (rd_data == prev_reg);
                quick_cv_next = (scan_idx_reg == '0) ? cpci_pkg::CV_LOW : y2_rom;
            end else begin
                prev_next     = rd_data;
                scan_idx_next = scan_idx_reg + IDX_W'(1);
            end
        end
        if (state_reg == cpci_pkg::ST_MUL) begin
            prod_next = cpci_pkg::PROD_W'(dy_reg) * cpci_pkg::PROD_W'(dx_reg);
        end
        if (div_start) begin
            neg_next = prod_neg ^ den_neg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= cpci_pkg::ST_IDLE;
            points_recorded_reg <= '0;
            table_done_reg      <= 1'b0;
            held_cv_reg         <= cpci_pkg::CV_LOW;
            m_valid_reg         <= 1'b0;
        end else begin
            state_reg           <= state_next;
            points_recorded_reg <= points_recorded_next;
            table_done_reg      <= table_done_next;
            held_cv_reg         <= held_cv_next;
            m_valid_reg         <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg   <= m_data_next;
        target_reg   <= target_next;
        scan_idx_reg <= scan_idx_next;
        prev_reg     <= prev_next;
        y1_reg       <= y1_next;
        dx_reg       <= dx_next;
        den_reg      <= den_next;
        dy_reg       <= dy_next;
        quick_reg    <= quick_next;
        quick_cv_reg <= quick_cv_next;
        prod_reg     <= prod_next;
        neg_reg      <= neg_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Checks
    `CPCI_ASSERT_IMPL(a_count_range, aclk, aresetn, 1'b1,
        points_recorded_reg <= CNT_W'(cpci_pkg::TABLE_POINTS), "point count above table size")
    `CPCI_ASSERT_NEXT(a_query_scans, aclk, aresetn,
        s_fire && (s_data.req_type == cpci_pkg::REQ_QUERY) && table_done_reg,
        state_reg == cpci_pkg::ST_SCAN, "query on complete table did not start scan")
    `CPCI_ASSERT_IMPL(a_done_source, aclk, aresetn, $rose(table_done_reg),
        $past(s_fire) && ($past(s_data.req_type) == cpci_pkg::REQ_CAL),
        "table marked complete without a calibration transaction")
    `CPCI_ASSERT_IMPL(a_div_owner, aclk, aresetn, div_rsp.done,
        state_reg == cpci_pkg::ST_DIV, "divider finished outside the divide state")

endmodule

@@ sim/calibrated_pitch_to_cv_interpolator_core_checker.sv @@
// Channel monitor, CV prediction and result comparison for the pitch-to-CV interpolator.
module calibrated_pitch_to_cv_interpolator_core_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  cpci_pkg::in_item_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  cpci_pkg::out_item_t m_data,
    output int                  mismatch_count,
    output int                  open_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HZ_W         = cpci_pkg::HZ_W;
    localparam int CNT_W        = cpci_pkg::CNT_W;
    localparam int CV_W         = cpci_pkg::CV_W;
    localparam int TABLE_POINTS = cpci_pkg::TABLE_POINTS;
    localparam int ROM_SIZE     = cpci_pkg::ROM_SIZE;

    // Shadow copy of the calibration state
    logic [HZ_W-1:0]        freq_tbl [TABLE_POINTS];
    logic [CNT_W-1:0]       rec_count;
    logic                   tbl_done;
    logic signed [CV_W-1:0] cur_cv;

    cpci_pkg::out_item_t expected_cv_q [$];
    int                  err_tally = 0;

    // One line per mismatch
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d expected %0d at %0t ns", what, got, want, $realtime);
        err_tally++;
    endtask

    // CV ROM read, clamped to the top entry
    function automatic logic signed [CV_W-1:0] rom_at(input int idx);
        return cpci_pkg::CV_ROM[(idx > ROM_SIZE - 1) ? ROM_SIZE - 1 : idx];
    endfunction

    function automatic logic signed [CV_W-1:0] saturate_cv(input longint v);
        if (v > 32767) begin
            return cpci_pkg::CV_MAX;
        end
        if (v < -32768) begin
            return cpci_pkg::CV_MIN;
        end
        return v[CV_W-1:0];
    endfunction

    // Table search, then linear inter/extrapolation with round-half-away division
    function automatic logic signed [CV_W-1:0] interp_cv(input logic [HZ_W-1:0] target);
        int     hit;
        longint x1, x2, y1, y2, den, num, mag, quo;
        logic   neg;
        hit = TABLE_POINTS - 1;
        for (int i = TABLE_POINTS - 1; i >= 0; i--) begin
            if (freq_tbl[i] >= target) begin
                hit = i;
            end
        end
        if (hit == 0) begin
            return cpci_pkg::CV_LOW;
        end
        x1  = longint'(freq_tbl[hit-1]);
        x2  = longint'(freq_tbl[hit]);
        y1  = longint'(rom_at(hit - 1));
        y2  = longint'(rom_at(hit));
        den = x2 - x1;
        num = (y2 - y1) * (longint'(target) - x1);
        // flat segment: take the upper CV
        if (den == 0) begin
            return saturate_cv(y2);
        end
        if (den < 0) begin
            den = -den;
            num = -num;
        end
        neg = (num < 0);
        mag = neg ? -num : num;
        quo = (mag + den / 2) / den;
        return saturate_cv(neg ? y1 - quo : y1 + quo);
    endfunction

    // Apply one transaction to the shadow state and return the expected result
    function automatic cpci_pkg::out_item_t next_result(input cpci_pkg::in_item_t item);
        cpci_pkg::out_item_t res;
        int                  nxt;
        if (item.req_type == cpci_pkg::REQ_CLEAR) begin
            rec_count = '0;
            tbl_done  = 1'b0;
            cur_cv    = cpci_pkg::CV_LOW;
        end
        // record switch off while still learning drops the CV to the bottom
        if (!item.record_on && !tbl_done) begin
            cur_cv = rom_at(0);
        end
        if (item.req_type == cpci_pkg::REQ_CAL && item.record_on && !tbl_done) begin
            if (int'(rec_count) < TABLE_POINTS) begin
                freq_tbl[rec_count] = item.value_hz;
                rec_count = rec_count + 1'b1;
                nxt = int'(rec_count);
                if (nxt > TABLE_POINTS - 1) begin
                    nxt = TABLE_POINTS - 1;
                end
                cur_cv = rom_at(nxt);
            end else begin
                // point after a full table: discard and mark complete
                tbl_done  = 1'b1;
                rec_count = '0;
            end
        end else if (item.req_type == cpci_pkg::REQ_QUERY && tbl_done) begin
            cur_cv = interp_cv(item.value_hz);
        end
        res.cv_out              = cur_cv;
        res.table_complete_flag = tbl_done;
        return res;
    endfunction

    // Watch both channels; results are handled before the new transaction is queued
    always @(posedge aclk) begin
        cpci_pkg::out_item_t want;
        if (!aresetn) begin
            rec_count = '0;
            tbl_done  = 1'b0;
            cur_cv    = cpci_pkg::CV_LOW;
            for (int i = 0; i < TABLE_POINTS; i++) begin
                freq_tbl[i] = '0;
            end
            expected_cv_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_cv_q.size() == 0) begin
                    report_mismatch("result with nothing pending, cv_out",
                                    int'(m_data.cv_out), 0);
                end else begin
                    want = expected_cv_q.pop_front();
                    if (m_data.cv_out !== want.cv_out) begin
                        report_mismatch("cv_out", int'(m_data.cv_out), int'(want.cv_out));
                    end
                    if (m_data.table_complete_flag !== want.table_complete_flag) begin
                        report_mismatch("table_complete_flag",
                                        int'(m_data.table_complete_flag),
                                        int'(want.table_complete_flag));
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_cv_q.insert(expected_cv_q.size(), next_result(s_data));
            end
        end
        mismatch_count <= err_tally;
        open_results   <= expected_cv_q.size();
    end

endmodule

@@ sim/calibrated_pitch_to_cv_interpolator_core_test.sv @@
// Stimulus, flow control and verdict for the pitch-to-CV interpolator testbench.
module calibrated_pitch_to_cv_interpolator_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          HZ_W         = cpci_pkg::HZ_W;
    localparam int          TABLE_POINTS = cpci_pkg::TABLE_POINTS;
    localparam int          RANDOM_ITEMS = 1500;
    localparam int          DRAIN_GUARD  = 20000;
    localparam int          DRAIN_CYCLES = 100;
    localparam logic [1:0]  REQ_UNUSED   = 2'd3;
    localparam logic [HZ_W-1:0] HZ_MAX   = {HZ_W{1'b1}};

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    cpci_pkg::in_item_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    cpci_pkg::out_item_t m_data;

    int mismatch_count;
    int open_results;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int sent_items         = 0;

    logic [HZ_W-1:0] cal_freq [TABLE_POINTS];

    always #6 aclk = ~aclk;

    calibrated_pitch_to_cv_interpolator_core DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    calibrated_pitch_to_cv_interpolator_core_checker cv_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .mismatch_count (mismatch_count),
        .open_results   (open_results)
    );

    // Receiver back-pressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // Drive one transaction; called and returns at a falling edge
    task automatic send_item(input logic [1:0] req, input logic [HZ_W-1:0] hz,
                             input logic rec);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < sender_idle_pct && gap < 40) begin
            gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_data.req_type  <= req;
        s_data.value_hz  <= hz;
        s_data.record_on <= rec;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
        if (req != REQ_UNUSED) begin
            sent_items++;
        end
    endtask

    // Watchdog
    initial begin
        #20_000_000;
        $display("[calibrated_pitch_to_cv_interpolator_core] ERROR");
        $finish;
    end

    initial begin
        int directed_items;
        int progress;
        int style;
        int span;
        int nxt;
        int nq;
        int pick;
        int k;
        int guard;
        logic [HZ_W-1:0] hz;
        logic [HZ_W-1:0] tgt;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: reset state, unused code, recording on and off, clear
        send_item(cpci_pkg::REQ_QUERY, '0, 1'b1);
        send_item(REQ_UNUSED, HZ_MAX, 1'b1);
        send_item(cpci_pkg::REQ_CAL, 24'h00_1000, 1'b0);
        send_item(cpci_pkg::REQ_CAL, '0, 1'b1);
        send_item(cpci_pkg::REQ_CAL, HZ_MAX, 1'b1);
        send_item(cpci_pkg::REQ_QUERY, HZ_MAX, 1'b1);
        send_item(cpci_pkg::REQ_CAL, 24'h55_5555, 1'b0);
        send_item(cpci_pkg::REQ_QUERY, 24'hAA_AAAA, 1'b0);
        send_item(cpci_pkg::REQ_CAL, 24'h01_2345, 1'b1);
        send_item(REQ_UNUSED, '0, 1'b0);
        send_item(cpci_pkg::REQ_CLEAR, HZ_MAX, 1'b1);
        send_item(cpci_pkg::REQ_CAL, 24'h00_0100, 1'b1);
        send_item(cpci_pkg::REQ_CLEAR, '0, 1'b0);
        send_item(cpci_pkg::REQ_QUERY, 24'h80_0000, 1'b1);
        directed_items = sent_items;

        // Random sessions: clear, learn a table, complete it, then query it
        while (sent_items < directed_items + RANDOM_ITEMS) begin
            progress = (sent_items - directed_items) * 4 / RANDOM_ITEMS;
            case (progress)
                0: begin
                    sender_idle_pct = 0;  receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct = 77; receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct = 0;  receiver_stall_pct = 77;
                end
                default: begin
                    sender_idle_pct = 12; receiver_stall_pct = 12;
                end
            endcase

            send_item(cpci_pkg::REQ_CLEAR, HZ_W'($urandom), 1'($urandom_range(0, 1)));

            // Table shapes: ascending, with repeats, unordered, steep, saturating at top
            style = $urandom_range(0, 4);
            case (style)
                1:       span = 512;
                3:       span = 16;
                4:       span = 600000;
                default: span = 4096;
            endcase
            hz = HZ_W'($urandom_range(0, 'h3FFF));
            for (int i = 0; i < TABLE_POINTS; i++) begin
                if (style == 2) begin
                    cal_freq[i] = HZ_W'($urandom);
                end else begin
                    cal_freq[i] = hz;
                    nxt = int'(hz) +
                          ((style == 1 && $urandom_range(0, 3) == 0) ? 0
                                                                     : $urandom_range(1, span));
                    hz = (nxt > int'(HZ_MAX)) ? HZ_MAX : nxt[HZ_W-1:0];
                end
            end

            // Learn the points, with an occasional stray transaction in between
            for (int i = 0; i < TABLE_POINTS; i++) begin
                if ($urandom_range(0, 15) == 0) begin
                    case ($urandom_range(0, 2))
                        0:       send_item(REQ_UNUSED, HZ_W'($urandom),
                                           1'($urandom_range(0, 1)));
                        1:       send_item(cpci_pkg::REQ_CAL, HZ_W'($urandom), 1'b0);
                        default: send_item(cpci_pkg::REQ_QUERY, HZ_W'($urandom),
                                           1'($urandom_range(0, 1)));
                    endcase
                end
                send_item(cpci_pkg::REQ_CAL, cal_freq[i], 1'b1);
            end

            // Sometimes leave the table unfinished
            if ($urandom_range(0, 7) == 0) begin
                continue;
            end
            send_item(cpci_pkg::REQ_CAL, HZ_W'($urandom), 1'b1);

            nq = $urandom_range(8, 40);
            repeat (nq) begin
                pick = $urandom_range(0, 9);
                k    = $urandom_range(0, TABLE_POINTS - 1);
                case (pick)
                    0:       tgt = '0;
                    1:       tgt = HZ_MAX;
                    2, 3:    tgt = cal_freq[k];
                    4, 5: begin
                        nxt = int'(cal_freq[k]) + $urandom_range(0, 64) - 32;
                        tgt = (nxt < 0) ? '0 : (nxt > int'(HZ_MAX)) ? HZ_MAX
                                                                    : nxt[HZ_W-1:0];
                    end
                    6:       tgt = HZ_W'($urandom);
                    default: tgt = HZ_W'($urandom_range(cal_freq[0],
                                                        cal_freq[TABLE_POINTS-1]));
                endcase
                if ($urandom_range(0, 9) == 0) begin
                    case ($urandom_range(0, 2))
                        0:       send_item(cpci_pkg::REQ_CAL, HZ_W'($urandom), 1'b1);
                        1:       send_item(REQ_UNUSED, HZ_W'($urandom),
                                           1'($urandom_range(0, 1)));
                        default: send_item(cpci_pkg::REQ_CAL, HZ_W'($urandom), 1'b0);
                    endcase
                end
                send_item(cpci_pkg::REQ_QUERY, tgt, 1'($urandom_range(0, 1)));
            end
        end
        s_valid <= 1'b0;

        // Drain outstanding results, then let the pipeline settle
        guard = 0;
        while (open_results != 0 && guard < DRAIN_GUARD) begin
            @(posedge aclk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && open_results == 0) begin
            $display("[calibrated_pitch_to_cv_interpolator_core] OK");
        end else begin
            $display("[calibrated_pitch_to_cv_interpolator_core] ERROR");
        end
        $finish;
    end

endmodule
